// ===== hdl/u8sd_pkg.sv =====
package u8sd_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int CP_WIDTH     = 21;
    localparam int OUT_OFF_W    = 16;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [CP_WIDTH-1:0]  code_point;
        logic [OUT_OFF_W-1:0] char_offset;
        status_t              status;
        logic                 end_of_string;
    } out_beat_t;

    // Sequence length of a lead byte; zero marks an invalid lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b[7] == 1'b0) begin
                len = 3'd1;
            end
            else if (b[7:6] == 2'b10) begin
                len = 3'd0;
            end
            else if (b[7:5] == 3'b110) begin
                len = 3'd2;
            end
            else if (b[7:4] == 4'b1110) begin
                len = 3'd3;
            end
            else if (b[7:3] == 5'b11110) begin
                len = 3'd4;
            end
            else begin
                len = 3'd0;
            end
            return len;
        end
    endfunction

endpackage

// ===== hdl/utf8_stream_decoder.sv =====
// Channel  | Handshake                  | Beat
// ---------+----------------------------+---------------------------------------------
// byte     | byte_valid / byte_ready    | byte_data: data_byte, last_byte
// cp       | cp_valid / cp_ready        | cp_data: code_point, char_offset, status, eos
//
// One byte per cycle while the cp beat is not stalled. A byte is held in the input
// register, is decoded against the sequence state, and its code point (if any)
// lands in the result register, which drives cp_valid.
// rst_n clears the sequence state, the offset counter and both valid flags.
// A stalled cp beat holds the pipeline; byte_ready stays high while the input
// register is empty or can advance.
module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_beat_t  byte_data,
    output logic      cp_valid,
    input  logic      cp_ready,
    output out_beat_t cp_data
);

    logic                    in_valid_reg;
    in_beat_t                in_beat_reg;
    logic                    out_valid_reg;
    out_beat_t               out_beat_reg;

    logic [1:0]              bytes_pending_reg;
    logic [1:0]              bytes_pending_next;
    logic [CP_WIDTH-1:0]     partial_value_reg;
    logic [CP_WIDTH-1:0]     partial_value_next;
    logic [OFFSET_WIDTH-1:0] lead_offset_reg;
    logic [OFFSET_WIDTH-1:0] lead_offset_next;
    logic [OFFSET_WIDTH-1:0] byte_count_reg;
    logic [OFFSET_WIDTH-1:0] byte_count_next;
    logic                    halted_reg;
    logic                    halted_next;

    logic                    advance;
    logic                    proc;
    logic                    emit;
    out_beat_t               result;
    logic [2:0]              len;
    logic [7:0]              b;

    assign advance    = !out_valid_reg || cp_ready;
    assign proc       = in_valid_reg && advance;
    assign byte_ready = !in_valid_reg || advance;
    assign cp_valid   = out_valid_reg;
    assign cp_data    = out_beat_reg;
    assign b          = in_beat_reg.data_byte;
    assign len        = lead_length(b);

    always_comb
    begin
        bytes_pending_next   = bytes_pending_reg;
        partial_value_next   = partial_value_reg;
        lead_offset_next     = lead_offset_reg;
        halted_next          = halted_reg;
        emit                 = 1'b0;
        result.code_point    = partial_value_reg;
        result.char_offset   = OUT_OFF_W'(lead_offset_reg);
        result.status        = ST_OK;
        result.end_of_string = in_beat_reg.last_byte;

        if (halted_reg)
        begin
            emit = 1'b0;
        end
        else if (bytes_pending_reg != 2'd0)
        begin
            partial_value_next = {partial_value_reg[CP_WIDTH-7:0], b[5:0]};
            bytes_pending_next = bytes_pending_reg - 2'd1;
            result.code_point  = partial_value_next;
            if (bytes_pending_next == 2'd0)
            begin
                emit = 1'b1;
            end
            else if (in_beat_reg.last_byte)
            begin
                emit          = 1'b1;
                result.status = ST_TRUNCATED;
            end
        end
        else
        begin
            lead_offset_next   = byte_count_reg;
            result.char_offset = OUT_OFF_W'(byte_count_reg);
            case (len)
                3'd1:
                begin
                    emit              = 1'b1;
                    result.code_point = CP_WIDTH'(b);
                end
                3'd0:
                begin
                    emit              = 1'b1;
                    halted_next       = 1'b1;
                    result.code_point = CP_WIDTH'(b[6:0]);
                    result.status     = ST_BAD_LEAD;
                end
                default:
                begin
                    partial_value_next = CP_WIDTH'(b & (8'h7F >> len));
                    bytes_pending_next = 2'(len - 3'd1);
                    result.code_point  = partial_value_next;
                    if (in_beat_reg.last_byte)
                    begin
                        emit          = 1'b1;
                        result.status = ST_TRUNCATED;
                    end
                end
            endcase
        end

        if (byte_count_reg != OFFSET_MAX)
        begin
            byte_count_next = byte_count_reg + OFFSET_WIDTH'(1);
        end
        else
        begin
            byte_count_next = byte_count_reg;
        end

        if (in_beat_reg.last_byte)
        begin
            bytes_pending_next = '0;
            partial_value_next = '0;
            lead_offset_next   = '0;
            byte_count_next    = '0;
            halted_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            bytes_pending_reg <= '0;
            partial_value_reg <= '0;
            lead_offset_reg   <= '0;
            byte_count_reg    <= '0;
            halted_reg        <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                out_valid_reg <= proc && emit;
            end
            if (proc)
            begin
                bytes_pending_reg <= bytes_pending_next;
                partial_value_reg <= partial_value_next;
                lead_offset_reg   <= lead_offset_next;
                byte_count_reg    <= byte_count_next;
                halted_reg        <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_beat_reg <= byte_data;
        end
        if (proc && emit)
        begin
            out_beat_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_beat_reg.last_byte |=>
            bytes_pending_reg == 2'd0 && !halted_reg && byte_count_reg == '0)
        else $error("state not cleared after last byte");

    a_halt_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> bytes_pending_reg == 2'd0)
        else $error("halted with bytes pending");

    a_bad_lead_halts: assert property (@(posedge clk) disable iff (!rst_n)
        proc && emit && result.status == ST_BAD_LEAD && !in_beat_reg.last_byte |=>
            halted_reg)
        else $error("bad lead byte did not halt decoding");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        proc && halted_reg |-> !emit)
        else $error("result emitted while halted");
`endif

endmodule

// ===== tb/sv/utf8_stream_decoder_test.sv =====
`timescale 1ns / 100ps

module utf8_stream_decoder_test;
    import u8sd_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_BYTES = 1250;
    localparam int LONG_BYTES   = 200;

    class code_point_tracker;
        logic [1:0]              seq_left;
        logic [CP_WIDTH-1:0]     seq_value;
        logic [OFFSET_WIDTH-1:0] seq_start;
        logic [OFFSET_WIDTH-1:0] next_offset;
        bit                      halted;
        out_beat_t               awaited_cps[$];
        int                      errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            seq_left    = '0;
            seq_value   = '0;
            seq_start   = '0;
            next_offset = '0;
            halted      = 1'b0;
        endfunction

        function void take_byte(in_beat_t b);
            out_beat_t               cp;
            logic [OFFSET_WIDTH-1:0] here;
            int unsigned             len;
            bit                      emit;
            here = next_offset;
            emit = 1'b0;
            cp.end_of_string = b.last_byte;
            if (halted)
            begin
                emit = 1'b0;
            end
            else if (seq_left != 0)
            begin
                seq_value = {seq_value[CP_WIDTH-7:0], b.data_byte[5:0]};
                seq_left  = seq_left - 1'b1;
                cp.code_point  = seq_value;
                cp.char_offset = OUT_OFF_W'(seq_start);
                if (seq_left == 0)
                begin
                    cp.status = ST_OK;
                    emit = 1'b1;
                end
                else if (b.last_byte)
                begin
                    cp.status = ST_TRUNCATED;
                    emit = 1'b1;
                end
            end
            else
            begin
                seq_start = here;
                cp.char_offset = OUT_OFF_W'(here);
                casez (b.data_byte)
                    8'b0???????: len = 1;
                    8'b110?????: len = 2;
                    8'b1110????: len = 3;
                    8'b11110???: len = 4;
                    default:     len = 0;
                endcase
                if (len == 1)
                begin
                    cp.code_point = CP_WIDTH'(b.data_byte);
                    cp.status = ST_OK;
                    emit = 1'b1;
                end
                else if (len == 0)
                begin
                    cp.code_point = CP_WIDTH'(b.data_byte[6:0]);
                    cp.status = ST_BAD_LEAD;
                    halted = 1'b1;
                    emit = 1'b1;
                end
                else
                begin
                    seq_value = CP_WIDTH'(b.data_byte & (8'h7F >> len));
                    seq_left  = 2'(len - 1);
                    if (b.last_byte)
                    begin
                        cp.code_point = seq_value;
                        cp.status = ST_TRUNCATED;
                        emit = 1'b1;
                    end
                end
            end
            if (next_offset != OFFSET_MAX)
                next_offset = next_offset + 1'b1;
            if (b.last_byte)
                clear();
            if (emit)
                awaited_cps = {awaited_cps, cp};
        endfunction

        task flag_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
            if (errors < 40)
                $display("%0t mismatch: %s got %0h want %0h", $time, what, got_v, want_v);
            errors++;
        endtask

        task match_code_point(out_beat_t got);
            out_beat_t want;
            if (awaited_cps.size() == 0)
            begin
                flag_mismatch("unexpected code point", 32'(got.code_point), 32'd0);
                return;
            end
            want = awaited_cps.pop_front();
            if (got.code_point !== want.code_point)
                flag_mismatch("code_point", 32'(got.code_point), 32'(want.code_point));
            if (got.char_offset !== want.char_offset)
                flag_mismatch("char_offset", 32'(got.char_offset), 32'(want.char_offset));
            if (got.status !== want.status)
                flag_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.end_of_string !== want.end_of_string)
                flag_mismatch("end_of_string", 32'(got.end_of_string),
                              32'(want.end_of_string));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_ready;
    in_beat_t  byte_data;
    logic      cp_valid;
    logic      cp_ready;
    out_beat_t cp_data;

    code_point_tracker tracker;
    int                items;
    bit                calm;
    bit                quiet;
    bit                hold_req;

    utf8_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_data    (cp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] d, input logic fin);
        in_beat_t b;
        b.data_byte = d;
        b.last_byte = fin;
        @(negedge clk);
        if (items == 400 || items == 1100)
            hold_req = 1'b1;
        if (!calm && !quiet && $urandom_range(0, 5) == 0)
        begin
            byte_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_data  = b;
        do
            @(posedge clk);
        while (!byte_ready);
        tracker.take_byte(b);
        items++;
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++)
        begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    // Mostly well-formed characters; rough strings add stray bytes, bad
    // continuations and a cut-off final character.
    task automatic send_string(input int min_bytes, input bit rough);
        logic [7:0] text[$];
        int         char_at;
        int         char_len;
        int         keep;
        char_len = 1;
        char_at  = 0;
        while (text.size() < min_bytes)
        begin
            char_at = text.size();
            if (rough && $urandom_range(0, 19) == 0)
            begin
                text = {text, 8'($urandom)};
                char_len = 1;
            end
            else
            begin
                char_len = $urandom_range(1, 4);
                case (char_len)
                    1: text = {text, {1'b0, 7'($urandom)}};
                    2: text = {text, {3'b110, 5'($urandom)}};
                    3: text = {text, {4'b1110, 4'($urandom)}};
                    default: text = {text, {5'b11110, 3'($urandom)}};
                endcase
                for (int k = 1; k < char_len; k++)
                begin
                    if (rough && $urandom_range(0, 9) == 0)
                        text = {text, 8'($urandom)};
                    else
                        text = {text, {2'b10, 6'($urandom)}};
                end
            end
        end
        if (rough && char_len > 1 && $urandom_range(0, 5) == 0)
        begin
            keep = char_at + $urandom_range(1, char_len - 1);
            while (text.size() > keep)
                text.delete(text.size() - 1);
        end
        send_text(text);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cp_valid && cp_ready)
            tracker.match_code_point(cp_data);
    end

    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(50, 300)) @(negedge clk);
            calm = !calm;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        cp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left != 0)
            begin
                cp_ready = 1'b0;
                stall_left--;
            end
            else
                cp_ready = 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("** utf8_stream_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        logic [7:0] text[$];
        tracker    = new();
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_data  = '0;
        items      = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all lengths, all but the 3-byte one at their extremes, unchecked continuation bits
        text = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                 8'hF7, 8'hBF, 8'hFF, 8'h3F, 8'h41};
        send_text(text);
        // bad lead, then drop until the end
        text = '{8'h80, 8'h41, 8'h41};
        send_text(text);
        text = '{8'hFF};
        send_text(text);
        // lead cut off as last byte
        text = '{8'hF0};
        send_text(text);
        text = '{8'hE1, 8'h9F};
        send_text(text);
        text = '{8'h41, 8'hF8, 8'hC2};
        send_text(text);
        text = '{8'hF4, 8'h8F, 8'hBF};
        send_text(text);

        while (items < RANDOM_BYTES)
            send_string($urandom_range(1, 40), 1'b1);

        // close with one clean string and no idling on either side
        quiet = 1'b1;
        send_string(LONG_BYTES, 1'b0);
        @(negedge clk);
        byte_valid = 1'b0;

        while (tracker.awaited_cps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("** utf8_stream_decoder: PASSED **");
        else
            $display("** utf8_stream_decoder: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/u8sd_pkg.sv
hdl/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_test.sv
